>>> design/lgts_pkg.sv
// Shared widths, register codes and saturating count helpers for the topic sampler.
`default_nettype none
package lgts_pkg;
   localparam int MAX_TOPICS  = 128;
   localparam int TOPIC_W     = 7;
   localparam int KCNT_W      = 8;
   localparam int DOC_W       = 8;
   localparam int POS_W       = 8;
   localparam int WORD_W      = 12;
   localparam int RND_W       = 16;
   localparam int CNT_W       = 16;
   localparam int TT_W        = 24;
   localparam int PRIOR_W     = 24;
   localparam int VOCAB_CFG_W = 13;
   localparam int Q_W         = 32;
   localparam int NUM_W       = 33;
   localparam int DEN_W       = 41;
   localparam int CLR_W       = WORD_W + TOPIC_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_TOPICS = 2'd0,
      CSR_VOCAB_SIZE = 2'd1,
      CSR_ALPHA      = 2'd2,
      CSR_BETA       = 2'd3
   } csr_index_type;

   function automatic logic [CNT_W-1:0] inc16(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] dec16(input logic [CNT_W-1:0] v);
      return (v == '0) ? v : v - 1'b1;
   endfunction

   function automatic logic [TT_W-1:0] inc24(input logic [TT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [TT_W-1:0] dec24(input logic [TT_W-1:0] v);
      return (v == '0) ? v : v - 1'b1;
   endfunction
endpackage
`default_nettype wire

>>> design/lgts_div.sv
// Radix-2 restoring divider: floor(num * 2^16 / den), saturated to 32 bits, zero for den of 0.
`default_nettype none
module lgts_div import lgts_pkg::*; (
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             start,
   input  wire  logic [NUM_W-1:0] num,
   input  wire  logic [DEN_W-1:0] den,
   output logic                   busy,
   output logic [Q_W-1:0]         quot
);
   localparam int CNT_DW = $clog2(Q_W);
   localparam int CMP_W  = DEN_W + 16;

   logic              busy_ff;
   logic [CNT_DW-1:0] cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [Q_W-1:0]    lo_ff;
   logic [Q_W-1:0]    quot_ff;

   logic [DEN_W:0]    trial;
   logic              fits;
   logic              sat;

   assign trial = {rem_ff, lo_ff[Q_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   // quotient would reach 2^32 when num >= den * 2^16
   assign sat   = CMP_W'(num) >= {den, 16'h0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         den_ff <= den;
         if (den == '0) begin
            quot_ff <= '0;
         end else if (sat) begin
            quot_ff <= '1;
         end else begin
            rem_ff  <= DEN_W'(num[NUM_W-1:16]);
            lo_ff   <= {num[15:0], 16'h0};
            cnt_ff  <= CNT_DW'(Q_W - 1);
            busy_ff <= 1'b1;
         end
      end else if (busy_ff) begin
         rem_ff  <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quot_ff <= {quot_ff[Q_W-2:0], fits};
         lo_ff   <= {lo_ff[Q_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

>>> design/lda_gibbs_topic_sampler.sv
// Initial assign: count read and write, then the result; resample weighs each active topic.
// Per topic the two 32-step dividers set the pace, then a read-and-compare search step
// per topic through the cumulative-weight memory. One item is in work at a time.
// Reset (synchronous) restores the registers and then clears the count memories, one entry
// per cycle; no item is taken during that pass, configuration is.
// Token topics are not cleared.
`default_nettype none
module lda_gibbs_topic_sampler import lgts_pkg::*; (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  logic                  req_tvalid,
   output logic                        req_tready,
   // doc[7:0], position[15:8], word[27:16], initial_topic[34:28], random_fraction[50:35]
   input  wire  logic [55:0]           req_tdata,
   // func[0]
   input  wire  logic                  req_tuser,
   output logic                        rsp_tvalid,
   input  wire  logic                  rsp_tready,
   // topic[6:0]
   output logic [7:0]                  rsp_tdata,
   input  wire  logic                  csr_wr_en,
   input  wire  logic [CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int DDEN_W = 33;
   localparam int VB_W   = VOCAB_CFG_W + PRIOR_W;
   localparam int KA_W   = KCNT_W + PRIOR_W;
   localparam logic [KCNT_W-1:0] TOPIC_LIMIT = KCNT_W'(MAX_TOPICS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_TOK_RD, S_TOK_WAIT, S_CNT_RD, S_CNT_WR, S_W_RD, S_W_DIV,
      S_W_WAIT, S_W_ACC, S_THR, S_S_RD, S_S_CMP, S_OUT
   } state_type;

   // configuration
   logic [KCNT_W-1:0]      num_topics_ff;
   logic [VOCAB_CFG_W-1:0] vocab_size_ff;
   logic [PRIOR_W-1:0]     alpha_ff;
   logic [PRIOR_W-1:0]     beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_topics_ff <= KCNT_W'(100);
         vocab_size_ff <= VOCAB_CFG_W'(4096);
         alpha_ff      <= PRIOR_W'(32768);
         beta_ff       <= PRIOR_W'(6554);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_TOPICS: num_topics_ff <= csr_wdata[KCNT_W-1:0];
            CSR_VOCAB_SIZE: vocab_size_ff <= csr_wdata[VOCAB_CFG_W-1:0];
            CSR_ALPHA:      alpha_ff      <= csr_wdata;
            CSR_BETA:       beta_ff       <= csr_wdata;
            default:        ;
         endcase
      end
   end

   state_type         state_ff;
   logic [CLR_W-1:0]  clr_ff;
   logic              inc_ff;
   logic [DOC_W-1:0]  doc_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0] word_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic [TOPIC_W-1:0] t_ff;
   logic [TOPIC_W-1:0] k_ff;
   logic [KCNT_W-1:0] k_act_ff;
   logic [KA_W-1:0]   kalpha_ff;
   logic [VB_W-1:0]   vbeta_ff;
   logic [DDEN_W-1:0] dden_ff;
   logic [63:0]       prod_ff;
   logic [Q_W-1:0]    acc_ff;
   logic [Q_W-1:0]    thr_ff;
   logic              rsp_tvalid_ff;
   logic [TOPIC_W-1:0] rsp_topic_ff;

   // memory read data
   logic [CNT_W-1:0]   wt_rd_ff;
   logic [CNT_W-1:0]   dt_rd_ff;
   logic [TT_W-1:0]    tt_rd_ff;
   logic [CNT_W-1:0]   dtot_rd_ff;
   logic [TOPIC_W-1:0] tok_rd_ff;
   logic [Q_W-1:0]     cw_rd_ff;

   logic [CNT_W-1:0]   wt_mem   [0:(1<<CLR_W)-1];
   logic [CNT_W-1:0]   dt_mem   [0:(1<<(DOC_W+TOPIC_W))-1];
   logic [TT_W-1:0]    tt_mem   [0:(1<<TOPIC_W)-1];
   logic [CNT_W-1:0]   dtot_mem [0:(1<<DOC_W)-1];
   logic [TOPIC_W-1:0] tok_mem  [0:(1<<(DOC_W+POS_W))-1];
   logic [Q_W-1:0]     cw_mem   [0:(1<<TOPIC_W)-1];

   logic               req_accept;
   logic               clearing;
   logic               cnt_wr;
   logic [KCNT_W-1:0]  k_act;
   logic [TOPIC_W-1:0] init_topic;
   logic [TOPIC_W-1:0] init_sat;
   logic [TOPIC_W-1:0] rd_topic;
   logic [TOPIC_W-1:0] last_k;
   logic [CNT_W-1:0]   wt_new;
   logic [CNT_W-1:0]   dt_new;
   logic [TT_W-1:0]    tt_new;
   logic [CNT_W-1:0]   dtot_new;
   logic [NUM_W-1:0]   num_w;
   logic [NUM_W-1:0]   num_d;
   logic [DEN_W-1:0]   den_w;
   logic [DEN_W-1:0]   den_d;
   logic               div_start;
   logic               busy_w;
   logic               busy_d;
   logic [Q_W-1:0]     fw;
   logic [Q_W-1:0]     fd;
   logic [Q_W-1:0]     weight;
   logic [Q_W:0]       acc_sum;
   logic [Q_W-1:0]     acc_new;
   logic [47:0]        thr_prod;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign clearing   = (state_ff == S_CLEAR);
   assign cnt_wr     = (state_ff == S_CNT_WR);

   assign k_act = (num_topics_ff == '0) ? KCNT_W'(1) :
                  (num_topics_ff > TOPIC_LIMIT) ? TOPIC_LIMIT : num_topics_ff;
   assign init_topic = req_tdata[34:28];
   assign init_sat   = ({1'b0, init_topic} >= k_act) ? TOPIC_W'(k_act - 1'b1) : init_topic;
   assign last_k     = TOPIC_W'(k_act_ff - 1'b1);
   assign rd_topic   = (state_ff == S_W_RD) ? k_ff : t_ff;

   assign wt_new   = inc_ff ? inc16(wt_rd_ff)   : dec16(wt_rd_ff);
   assign dt_new   = inc_ff ? inc16(dt_rd_ff)   : dec16(dt_rd_ff);
   assign tt_new   = inc_ff ? inc24(tt_rd_ff)   : dec24(tt_rd_ff);
   assign dtot_new = inc_ff ? inc16(dtot_rd_ff) : dec16(dtot_rd_ff);

   // memories: clear sweep or read-modify-write of the counts
   always_ff @(posedge clock) begin
      if (clearing || cnt_wr) begin
         wt_mem[clearing ? clr_ff : {word_ff, t_ff}] <= clearing ? '0 : wt_new;
      end
      wt_rd_ff <= wt_mem[{word_ff, rd_topic}];
   end

   always_ff @(posedge clock) begin
      if (clearing || cnt_wr) begin
         dt_mem[clearing ? clr_ff[DOC_W+TOPIC_W-1:0] : {doc_ff, t_ff}] <=
            clearing ? '0 : dt_new;
      end
      dt_rd_ff <= dt_mem[{doc_ff, rd_topic}];
   end

   always_ff @(posedge clock) begin
      if (clearing || cnt_wr) begin
         tt_mem[clearing ? clr_ff[TOPIC_W-1:0] : t_ff] <= clearing ? '0 : tt_new;
      end
      tt_rd_ff <= tt_mem[rd_topic];
   end

   always_ff @(posedge clock) begin
      if (clearing || cnt_wr) begin
         dtot_mem[clearing ? clr_ff[DOC_W-1:0] : doc_ff] <= clearing ? '0 : dtot_new;
      end
      dtot_rd_ff <= dtot_mem[doc_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_wr && inc_ff) begin
         tok_mem[{doc_ff, pos_ff}] <= t_ff;
      end
      tok_rd_ff <= tok_mem[{doc_ff, pos_ff}];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_W_ACC) begin
         cw_mem[k_ff] <= acc_new;
      end
      cw_rd_ff <= cw_mem[k_ff];
   end

   // ratio operands
   assign num_w = NUM_W'({wt_rd_ff, 16'h0}) + NUM_W'(beta_ff);
   assign den_w = DEN_W'({tt_rd_ff, 16'h0}) + DEN_W'(vbeta_ff);
   assign num_d = NUM_W'({dt_rd_ff, 16'h0}) + NUM_W'(alpha_ff);
   assign den_d = DEN_W'(dden_ff);
   assign div_start = (state_ff == S_W_DIV);

   lgts_div u_div_word (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_w),
      .den   (den_w),
      .busy  (busy_w),
      .quot  (fw)
   );

   lgts_div u_div_doc (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_d),
      .den   (den_d),
      .busy  (busy_d),
      .quot  (fd)
   );

   assign weight   = (|prod_ff[63:48]) ? '1 : prod_ff[47:16];
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, weight};
   assign acc_new  = acc_sum[Q_W] ? '1 : acc_sum[Q_W-1:0];
   assign thr_prod = acc_ff * rnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // S_OUT drives the valid flag itself
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  doc_ff    <= req_tdata[7:0];
                  pos_ff    <= req_tdata[15:8];
                  word_ff   <= req_tdata[27:16];
                  rnd_ff    <= req_tdata[50:35];
                  k_act_ff  <= k_act;
                  kalpha_ff <= k_act * alpha_ff;
                  vbeta_ff  <= vocab_size_ff * beta_ff;
                  inc_ff    <= !req_tuser;
                  t_ff      <= init_sat;
                  state_ff  <= req_tuser ? S_TOK_RD : S_CNT_RD;
               end
            end
            S_TOK_RD:   state_ff <= S_TOK_WAIT;
            S_TOK_WAIT: begin
               t_ff     <= tok_rd_ff;
               state_ff <= S_CNT_RD;
            end
            S_CNT_RD:   state_ff <= S_CNT_WR;
            S_CNT_WR: begin
               if (inc_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  dden_ff  <= DDEN_W'({dtot_new, 16'h0}) + DDEN_W'(kalpha_ff);
                  acc_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= S_W_RD;
               end
            end
            S_W_RD:  state_ff <= S_W_DIV;
            S_W_DIV: state_ff <= S_W_WAIT;
            S_W_WAIT: begin
               if (!busy_w && !busy_d) begin
                  prod_ff  <= fw * fd;
                  state_ff <= S_W_ACC;
               end
            end
            S_W_ACC: begin
               acc_ff <= acc_new;
               if (k_ff == last_k) begin
                  state_ff <= S_THR;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_W_RD;
               end
            end
            S_THR: begin
               thr_ff   <= thr_prod[47:16];
               k_ff     <= '0;
               state_ff <= S_S_RD;
            end
            S_S_RD: state_ff <= S_S_CMP;
            S_S_CMP: begin
               // first topic above the threshold wins, else the last active topic
               if (cw_rd_ff > thr_ff || k_ff == last_k) begin
                  t_ff     <= k_ff;
                  inc_ff   <= 1'b1;
                  state_ff <= S_CNT_RD;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_S_RD;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_topic_ff  <= t_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_topic_ff};

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("accepted item did not start work");

   a_div_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      (busy_w || busy_d) |-> state_ff == S_W_WAIT)
      else $error("divider busy outside weight wait");

   a_topic_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> {1'b0, t_ff} < k_act_ff)
      else $error("chosen topic beyond active topic count");
endmodule
`default_nettype wire

>>> tb/tb_lda_gibbs_topic_sampler.sv
// Self-checking testbench for the LDA collapsed Gibbs topic sampler.
`timescale 1ns / 1ps
`default_nettype none
module tb_lda_gibbs_topic_sampler;
   import lgts_pkg::*;

   localparam int IDLE_LIMIT = 2000000;
   localparam int LONG_HOLD  = 3000;
   localparam bit FN_ASSIGN   = 1'b0;
   localparam bit FN_RESAMPLE = 1'b1;

   typedef struct {
      bit [7:0]  doc;
      bit [7:0]  pos;
      bit [11:0] word;
   } token_ref_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lda_gibbs_topic_sampler dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the sampler state
   bit [7:0]  k_cfg;
   bit [12:0] vocab_cfg;
   bit [23:0] alpha_cfg;
   bit [23:0] beta_cfg;
   bit [15:0] word_topic_cnt [0:524287];
   bit [15:0] doc_topic_cnt  [0:32767];
   bit [23:0] topic_sum      [0:127];
   bit [15:0] doc_sum        [0:255];
   bit [6:0]  token_topic    [0:65535];

   bit [6:0]      topic_queue[$];
   token_ref_type placed_tokens[$];
   int            error_count;
   int            stall_req, stall_ack;
   bit            rx_eager;

   function automatic longint unsigned q16_ratio(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return 0;
      q = (num << 16) / den;
      return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic void update_counts(bit [11:0] w, bit [7:0] d, bit [6:0] t, bit add);
      int wi, di;
      wi = {w, t};
      di = {d, t};
      if (add) begin
         if (word_topic_cnt[wi] != 16'hFFFF) word_topic_cnt[wi]++;
         if (doc_topic_cnt[di] != 16'hFFFF) doc_topic_cnt[di]++;
         if (topic_sum[t] != 24'hFFFFFF) topic_sum[t]++;
         if (doc_sum[d] != 16'hFFFF) doc_sum[d]++;
      end else begin
         if (word_topic_cnt[wi] != 0) word_topic_cnt[wi]--;
         if (doc_topic_cnt[di] != 0) doc_topic_cnt[di]--;
         if (topic_sum[t] != 0) topic_sum[t]--;
         if (doc_sum[d] != 0) doc_sum[d]--;
      end
   endfunction

   function automatic bit [6:0] sample_topic(bit fn, bit [7:0] d, bit [7:0] p, bit [11:0] w,
                                              bit [6:0] init_t, bit [15:0] r);
      int unsigned kk, t;
      longint unsigned acc, thr, vbeta, dden, fw, fd, wt;
      longint unsigned cum [0:127];
      kk = (k_cfg == 0) ? 1 : ((k_cfg > MAX_TOPICS) ? MAX_TOPICS : k_cfg);
      if (fn == FN_ASSIGN) begin
         t = (init_t >= kk) ? kk - 1 : init_t;
      end else begin
         t = token_topic[{d, p}];
         update_counts(w, d, t[6:0], 1'b0);
         vbeta = longint'(vocab_cfg) * beta_cfg;
         dden = (longint'(doc_sum[d]) << 16) + longint'(kk) * alpha_cfg;
         acc = 0;
         for (int k = 0; k < kk; k++) begin
            fw = q16_ratio((longint'(word_topic_cnt[{w, k[6:0]}]) << 16) + beta_cfg,
                           (longint'(topic_sum[k]) << 16) + vbeta);
            fd = q16_ratio((longint'(doc_topic_cnt[{d, k[6:0]}]) << 16) + alpha_cfg, dden);
            wt = (fw * fd) >> 16;
            if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
            acc += wt;
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            cum[k] = acc;
         end
         thr = (cum[kk-1] * r) >> 16;
         t = kk - 1;
         for (int k = 0; k < kk; k++) begin
            if (cum[k] > thr) begin
               t = k;
               break;
            end
         end
      end
      token_topic[{d, p}] = t[6:0];
      update_counts(w, d, t[6:0], 1'b1);
      return t[6:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Write all four registers while the block is idle
   task automatic set_config(bit [7:0] k, bit [12:0] v, bit [23:0] a, bit [23:0] b);
      csr_index_type idx[4] = '{CSR_NUM_TOPICS, CSR_VOCAB_SIZE, CSR_ALPHA, CSR_BETA};
      bit [23:0] val[4];
      val = '{24'(k), 24'(v), a, b};
      // drop valid so the last item is not taken again
      req_tvalid <= 1'b0;
      while (topic_queue.size() != 0) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      k_cfg = k; vocab_cfg = v; alpha_cfg = a; beta_cfg = b;
   endtask

   // Offer one item after a gap; valid stays high between back-to-back transfers
   task automatic send_item(bit fn, bit [7:0] d, bit [7:0] p, bit [11:0] w,
                            bit [6:0] init_t, bit [15:0] r, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {5'b0, r, init_t, w, p, d};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      topic_queue.push_back(sample_topic(fn, d, p, w, init_t, r));
      if (fn == FN_ASSIGN) placed_tokens.push_back('{d, p, w});
   endtask

   task automatic send_random(int gap);
      token_ref_type tk;
      int r;
      r = $urandom_range(0, 99);
      if (placed_tokens.size() == 0 || r < 30) begin
         tk.doc  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         tk.pos  = 8'($urandom);
         tk.word = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
         send_item(FN_ASSIGN, tk.doc, tk.pos, tk.word, 7'($urandom), 16'($urandom), gap);
      end else begin
         tk = placed_tokens[$urandom_range(0, placed_tokens.size() - 1)];
         // mostly resample with the token's own word, sometimes another word
         if (r > 92) tk.word = 12'($urandom);
         send_item(FN_RESAMPLE, tk.doc, tk.pos, tk.word, 7'($urandom), 16'($urandom), gap);
      end
   endtask

   task automatic test_directed();
      set_config(8'd4, 13'd4096, 24'd32768, 24'd6554);
      send_item(FN_ASSIGN, 8'd255, 8'd255, 12'd4095, 7'd127, 16'hFFFF, 0);
      send_item(FN_ASSIGN, 8'd0, 8'd0, 12'd0, 7'd0, 16'h0000, 0);
      send_item(FN_ASSIGN, 8'd0, 8'd1, 12'd0, 7'd2, 16'h0000, 0);
      send_item(FN_RESAMPLE, 8'd255, 8'd255, 12'd4095, 7'd0, 16'h0000, 0);
      send_item(FN_RESAMPLE, 8'd0, 8'd0, 12'd0, 7'd0, 16'hFFFF, 0);
      send_item(FN_RESAMPLE, 8'd0, 8'd1, 12'd4095, 7'd127, 16'h8000, 2);
      // zero priors on an otherwise empty document: zero denominator, all weights zero
      set_config(8'd6, 13'd0, 24'd0, 24'd0);
      send_item(FN_ASSIGN, 8'd77, 8'd3, 12'd9, 7'd3, 16'h1234, 0);
      send_item(FN_RESAMPLE, 8'd77, 8'd3, 12'd9, 7'd0, 16'h0001, 0);
      // stale topic: assign high, then shrink K and resample
      set_config(8'd16, 13'd8191, 24'hFFFFFF, 24'hFFFFFF);
      send_item(FN_ASSIGN, 8'd12, 8'd40, 12'd100, 7'd15, 16'h0, 0);
      send_item(FN_RESAMPLE, 8'd12, 8'd40, 12'd100, 7'd0, 16'hFFFF, 0);
      set_config(8'd2, 13'd1, 24'd1, 24'd1);
      send_item(FN_RESAMPLE, 8'd12, 8'd40, 12'd100, 7'd0, 16'h7FFF, 0);
      send_item(FN_ASSIGN, 8'd12, 8'd41, 12'd100, 7'd99, 16'h0, 0);
      // K of zero acts as one topic
      set_config(8'd0, 13'd4096, 24'd32768, 24'd6554);
      send_item(FN_ASSIGN, 8'd5, 8'd5, 12'd5, 7'd64, 16'h0, 0);
      send_item(FN_RESAMPLE, 8'd5, 8'd5, 12'd5, 7'd0, 16'hFFFF, 0);
      // K beyond the topic memory clamps to its size
      set_config(8'd255, 13'd4096, 24'd32768, 24'd6554);
      send_item(FN_ASSIGN, 8'd6, 8'd6, 12'd6, 7'd127, 16'h0, 0);
      send_item(FN_RESAMPLE, 8'd6, 8'd6, 12'd6, 7'd0, 16'hC000, 0);
      set_config(8'd128, 13'd4096, 24'd32768, 24'd6554);
      send_item(FN_RESAMPLE, 8'd255, 8'd255, 12'd4095, 7'd0, 16'h4000, 0);
   endtask

   task automatic test_random_phases();
      bit [7:0] k;
      for (int ph = 0; ph < 8; ph++) begin
         k = (ph == 7) ? 8'd128 : 8'($urandom_range(2, 16));
         set_config(k, 13'($urandom_range(1, 8191)), 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23)),
                    24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23)));
         rx_eager = (ph % 3 == 1);
         for (int i = 0; i < ((ph == 7) ? 8 : 50); i++)
            send_random((ph % 3 == 2) ? 0 : pick_gap());
         rx_eager = 1'b0;
      end
   endtask

   task automatic test_output_stall();
      set_config(8'd8, 13'd4096, 24'd32768, 24'd6554);
      stall_req++;
      for (int i = 0; i < 10; i++) send_random(0);
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 10; i++) send_random(pick_gap());
      req_tvalid <= 1'b0;
      while (topic_queue.size() != 0) @(posedge clock);
      for (int i = 0; i < 10; i++) send_random(pick_gap());
   endtask

   // Result receiver: random gaps, and a long hold-off on request
   always @(posedge clock) begin : rx_ready
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold = 0;
      end else if (stall_ack != stall_req) begin
         stall_ack = stall_req;
         hold = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold > 0) begin
         hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         hold = rx_eager ? 0 : pick_gap();
      end
   end

   // Result check: sample mid-cycle, the transfer completes at the next edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (topic_queue.size() == 0)
            report_mismatch("unexpected result, topic", rsp_tdata[6:0], -1);
         else if (rsp_tdata[6:0] != topic_queue[0])
            report_mismatch("topic", rsp_tdata[6:0], topic_queue[0]);
         if (topic_queue.size() != 0) void'(topic_queue.pop_front());
      end
   end

   always @(negedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      stall_req = 0;
      stall_ack = 0;
      rx_eager = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phases();
      test_output_stall();
      test_drain_pause();
      req_tvalid <= 1'b0;
      while (topic_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
